// ----- hdl/tst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the tone stream transcoder.
// No dependencies.
package tst_pkg;

  localparam int unsigned MAX_CHUNK = 127;
  localparam logic [6:0]  CHUNK_MAX = 7'(MAX_CHUNK);
  localparam logic [11:0] FRAMES_MAX = 12'(31 * MAX_CHUNK - 1);
  localparam logic [18:0] DIV50_K = 19'd335545;
  localparam logic [19:0] CNT_MAX = 20'hFFFFF;
  localparam logic [7:0]  JUMP_OP = 8'hD0;
  localparam logic [7:0]  NOTE_LO = 8'd12;
  localparam logic [7:0]  NOTE_HI = 8'd106;
  localparam logic [3:0]  KIND_ON = 4'h9;
  localparam logic [3:0]  KIND_OFF = 4'h8;

  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_STEP = 2'd1;
  localparam logic [1:0] CFG_SEGB = 2'd2;
  localparam logic [1:0] CFG_TOL  = 2'd3;

  typedef enum logic [3:0] {
    SEL_NOTE_CMD,
    SEL_NOTE_VAL,
    SEL_IN,
    SEL_CHUNK,
    SEL_JUMP_OP,
    SEL_SEG_LO,
    SEL_SEG_HI,
    SEL_BASE_LO,
    SEL_BASE_HI
  } emit_sel_e;

  typedef struct packed {
    logic      latch;
    logic      acc;
    logic      set_high;
    logic      set_note;
    logic      fl_start;
    logic      fl_mul;
    logic      fl_frames;
    logic      ch_up;
    logic      ch_dn;
    logic      seg_hit;
    logic      stream_rst;
    logic      emit;
    emit_sel_e emit_sel;
    logic      close;
  } cmd_t;

  typedef struct packed {
    logic b7;
    logic kind_on;
    logic kind_off;
    logic end_flag;
    logic pending;
    logic accum_zero;
    logic frames_zero;
    logic last_chunk;
    logic seg_hit;
    logic emit_ok;
    logic done_ok;
    logic pend_valid;
  } status_t;

  function automatic logic [15:0] seg_cap(input logic [15:0] sb);
    logic [15:0] r;
    if (sb == 16'd0) r = 16'd0;
    else if (sb < 16'd5) r = 16'd1;
    else r = sb - 16'd4;
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7FFFFFFF;
    else if (v < -34'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] err_after(input logic [31:0] te,
                                                   input logic [6:0] c);
    logic [12:0] c50;
    c50 = {1'b0, c, 5'd0} + {2'b0, c, 4'd0} + {5'd0, c, 1'b0};
    return $signed({{2{te[31]}}, te}) - $signed({21'd0, c50});
  endfunction

endpackage

// ----- hdl/tst_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the source and result byte channels.
// No dependencies.
interface tst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, in_byte, stream_end, input ready);
  modport sink (input valid, in_byte, stream_end, output ready);
endinterface

interface tst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       jump_done;
  modport source (output valid, out_byte, run_last, jump_done, input ready);
  modport sink (input valid, out_byte, run_last, jump_done, output ready);
endinterface

// ----- hdl/tst_dp.sv -----
`timescale 1ns / 1ps
// Datapath: configuration, parse and timing state, frame arithmetic, output register.
// Depends on tst_pkg.
module tst_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tst_pkg::cmd_t    cmd_i,
  output tst_pkg::status_t status_o,
  input  logic [7:0]       in_byte_i,
  input  logic             stream_end_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             jump_done_o
);
  import tst_pkg::*;

  logic [15:0] base_q, step_q, segb_q;
  logic [7:0]  tol_q;
  logic [7:0]  b_q;
  logic        end_q;
  logic [6:0]  high_q;
  logic [15:0] accum_q;
  logic        pending_q;
  logic [31:0] te_q;
  logic [19:0] cnt_q, nb_q;
  logic [15:0] ptr_q;
  logic [7:0]  note_q;
  logic [17:0] n_q;
  logic [36:0] prod_q;
  logic [11:0] rem_q;
  logic [6:0]  c_q;
  logic        pend_valid_q, pend_jump_q;
  logic [7:0]  pend_byte_q;
  logic        out_valid_q, out_last_q, out_jump_q;
  logic [7:0]  out_byte_q;

  logic [15:0] cap;
  logic [16:0] acc_sum;
  logic [17:0] d3;
  logic [12:0] frames_raw;
  logic [11:0] frames;
  logic [6:0]  base_c;
  logic [13:0] lim;
  logic signed [37:0] x_up, x_dn;
  logic        raise, lower;
  logic [7:0]  note_val, emit_byte;
  logic        emit_jump;
  logic [1:0]  cnt_k;
  logic [20:0] cnt_sum, nb_sum;
  logic        out_free, push;

  assign cap = seg_cap(segb_q);
  assign acc_sum = {1'b0, accum_q} + {2'b0, high_q, b_q};
  assign d3 = {1'b0, accum_q, 1'b0} + {2'b0, accum_q};
  assign frames_raw = prod_q[36:24];
  assign frames = (frames_raw > {1'b0, FRAMES_MAX}) ? FRAMES_MAX : frames_raw[11:0];
  assign base_c = (rem_q >= 12'(MAX_CHUNK)) ? CHUNK_MAX : rem_q[6:0];
  assign lim = {tol_q, 5'd0} + {1'b0, tol_q, 4'd0} + {4'd0, tol_q, 1'b0};
  assign x_up = {err_after(te_q, base_c), 4'd0};
  assign x_dn = {err_after(te_q, c_q), 4'd0};
  assign raise = (tol_q != 8'd0) && (x_up > $signed({24'd0, lim}))
                 && (base_c != CHUNK_MAX);
  assign lower = (tol_q != 8'd0) && (x_dn < -$signed({24'd0, lim}))
                 && (c_q > 7'd1);

  assign note_val = (b_q < NOTE_LO) ? NOTE_LO : ((b_q > NOTE_HI) ? NOTE_HI : b_q);

  always_comb begin
    emit_jump = 1'b0;
    case (cmd_i.emit_sel)
      SEL_NOTE_CMD: emit_byte = note_q;
      SEL_NOTE_VAL: emit_byte = note_val;
      SEL_IN:       emit_byte = b_q;
      SEL_CHUNK:    emit_byte = {1'b0, c_q};
      SEL_JUMP_OP:  emit_byte = JUMP_OP;
      SEL_SEG_LO:   emit_byte = ptr_q[7:0];
      SEL_SEG_HI: begin
        emit_byte = ptr_q[15:8];
        emit_jump = 1'b1;
      end
      SEL_BASE_LO:  emit_byte = base_q[7:0];
      SEL_BASE_HI: begin
        emit_byte = base_q[15:8];
        emit_jump = 1'b1;
      end
      default:      emit_byte = 8'd0;
    endcase
  end

  always_comb begin
    cnt_k = 2'd0;
    if (cmd_i.seg_hit) cnt_k = 2'd3;
    else if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        SEL_NOTE_VAL: cnt_k = 2'd2;
        SEL_IN:       cnt_k = 2'd1;
        SEL_CHUNK:    cnt_k = 2'd1;
        default:      cnt_k = 2'd0;
      endcase
    end
  end
  assign cnt_sum = {1'b0, cnt_q} + {19'd0, cnt_k};
  assign nb_sum = {1'b0, nb_q} + {5'd0, cap};

  assign out_free = !out_valid_q || out_ready_i;
  assign push = pend_valid_q && (cmd_i.emit || cmd_i.close);

  assign status_o.b7 = b_q[7];
  assign status_o.kind_on = b_q[7:4] == KIND_ON;
  assign status_o.kind_off = b_q[7:4] == KIND_OFF;
  assign status_o.end_flag = end_q;
  assign status_o.pending = pending_q;
  assign status_o.accum_zero = accum_q == 16'd0;
  assign status_o.frames_zero = frames == 12'd0;
  assign status_o.last_chunk = rem_q < 12'(MAX_CHUNK);
  assign status_o.seg_hit = (step_q != 16'd0) && (cap != 16'd0) && (cnt_q >= nb_q);
  assign status_o.emit_ok = !pend_valid_q || out_free;
  assign status_o.done_ok = !pend_valid_q || out_free;
  assign status_o.pend_valid = pend_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      b_q <= in_byte_i;
      end_q <= stream_end_i;
    end
    if (cmd_i.fl_start) n_q <= d3 + 18'd24;
    if (cmd_i.fl_mul) prod_q <= 37'(n_q) * 37'(DIV50_K);
    if (cmd_i.ch_up) c_q <= raise ? base_c + 7'd1 : base_c;
    else if (cmd_i.ch_dn && lower) c_q <= c_q - 7'd1;
    if (cmd_i.fl_frames) rem_q <= frames;
    else if (cmd_i.emit && cmd_i.emit_sel == SEL_CHUNK && !status_o.last_chunk)
      rem_q <= rem_q - 12'(MAX_CHUNK);
    if (cmd_i.emit) begin
      pend_byte_q <= emit_byte;
      pend_jump_q <= emit_jump;
    end
    if (push && out_free) begin
      out_byte_q <= pend_byte_q;
      out_jump_q <= pend_jump_q;
      out_last_q <= cmd_i.close;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 16'h8000;
      step_q <= 16'd0;
      segb_q <= 16'd0;
      tol_q <= 8'd8;
      high_q <= 7'd0;
      accum_q <= 16'd0;
      pending_q <= 1'b0;
      te_q <= 32'd0;
      cnt_q <= 20'd0;
      nb_q <= 20'd0;
      ptr_q <= 16'h8000;
      note_q <= 8'd0;
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_high) high_q <= b_q[6:0];
      if (cmd_i.set_note) note_q <= b_q;
      if (cmd_i.acc) begin
        accum_q <= acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
        pending_q <= 1'b1;
      end
      if (cmd_i.fl_start) begin
        accum_q <= 16'd0;
        pending_q <= 1'b0;
        te_q <= sat32($signed({{2{te_q[31]}}, te_q}) + $signed({16'd0, d3}));
      end
      if (cmd_i.emit && cmd_i.emit_sel == SEL_CHUNK)
        te_q <= sat32(err_after(te_q, c_q));
      cnt_q <= cnt_sum[20] ? CNT_MAX : cnt_sum[19:0];
      if (cmd_i.seg_hit) begin
        ptr_q <= ptr_q + step_q;
        nb_q <= nb_sum[20] ? CNT_MAX : nb_sum[19:0];
      end
      if (cmd_i.emit) pend_valid_q <= 1'b1;
      else if (cmd_i.close && out_free) pend_valid_q <= 1'b0;
      if (push && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.stream_rst) begin
        high_q <= 7'd0;
        accum_q <= 16'd0;
        pending_q <= 1'b0;
        te_q <= 32'd0;
        cnt_q <= 20'd0;
        nb_q <= {4'd0, cap};
        ptr_q <= base_q;
        note_q <= 8'd0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE: begin
            base_q <= cfg_data_i;
            ptr_q <= cfg_data_i;
          end
          CFG_STEP: step_q <= cfg_data_i;
          CFG_SEGB: begin
            segb_q <= cfg_data_i;
            nb_q <= {4'd0, seg_cap(cfg_data_i)};
          end
          CFG_TOL:  tol_q <= cfg_data_i[7:0];
          default:  tol_q <= tol_q;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign run_last_o = out_last_q;
  assign jump_done_o = out_jump_q;

endmodule

// ----- hdl/tst_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: parse phase and the sequence of datapath steps for one source byte.
// Depends on tst_pkg.
module tst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tst_pkg::status_t status_i,
  output tst_pkg::cmd_t    cmd_o
);
  import tst_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE      = 20'h00001,
    ST_DISPATCH  = 20'h00002,
    ST_NOTE_CMD  = 20'h00004,
    ST_NOTE_VAL  = 20'h00008,
    ST_KIND      = 20'h00010,
    ST_OFF_EMIT  = 20'h00020,
    ST_FL_START  = 20'h00040,
    ST_FL_MUL    = 20'h00080,
    ST_FL_FRAMES = 20'h00100,
    ST_CH_UP     = 20'h00200,
    ST_CH_DN     = 20'h00400,
    ST_CH_EMIT   = 20'h00800,
    ST_SEG       = 20'h01000,
    ST_SEG_D0    = 20'h02000,
    ST_SEG_LO    = 20'h04000,
    ST_SEG_HI    = 20'h08000,
    ST_FIN_D0    = 20'h10000,
    ST_FIN_LO    = 20'h20000,
    ST_FIN_HI    = 20'h40000,
    ST_DONE      = 20'h80000
  } state_e;

  localparam logic [1:0] PH_CMD = 2'd0;
  localparam logic [1:0] PH_NOTE = 2'd1;
  localparam logic [1:0] PH_DELAY = 2'd2;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       pre_q, pre_d;
  state_e     flush_exit, after_cmd;

  assign in_ready_o = state_q == ST_IDLE;
  assign flush_exit = pre_q ? ST_SEG : ST_FIN_D0;
  assign after_cmd = status_i.end_flag ? ST_FIN_D0 : ST_SEG;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pre_d = pre_q;
    cmd_o = '0;
    cmd_o.emit_sel = SEL_JUMP_OP;
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        phase_d = PH_CMD;
        pre_d = 1'b0;
        if (phase_q == PH_NOTE) begin
          state_d = ST_NOTE_CMD;
        end else if (phase_q == PH_DELAY) begin
          cmd_o.acc = 1'b1;
          state_d = status_i.end_flag ? ST_FL_START : ST_DONE;
        end else if (status_i.b7) begin
          if (status_i.pending) begin
            pre_d = 1'b1;
            state_d = ST_FL_START;
          end else begin
            state_d = ST_KIND;
          end
        end else if (status_i.end_flag) begin
          state_d = ST_FL_START;
        end else begin
          cmd_o.set_high = 1'b1;
          phase_d = PH_DELAY;
          state_d = ST_DONE;
        end
      end
      ST_NOTE_CMD: begin
        cmd_o.emit_sel = SEL_NOTE_CMD;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = ST_NOTE_VAL;
      end
      ST_NOTE_VAL: begin
        cmd_o.emit_sel = SEL_NOTE_VAL;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = after_cmd;
      end
      ST_KIND: begin
        if (status_i.kind_on) begin
          if (status_i.end_flag) begin
            state_d = ST_FIN_D0;
          end else begin
            cmd_o.set_note = 1'b1;
            phase_d = PH_NOTE;
            state_d = ST_DONE;
          end
        end else if (status_i.kind_off) begin
          state_d = ST_OFF_EMIT;
        end else begin
          state_d = after_cmd;
        end
      end
      ST_OFF_EMIT: begin
        cmd_o.emit_sel = SEL_IN;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = after_cmd;
      end
      ST_FL_START: begin
        cmd_o.fl_start = 1'b1;
        if (!status_i.pending || status_i.accum_zero) state_d = flush_exit;
        else state_d = ST_FL_MUL;
      end
      ST_FL_MUL: begin
        cmd_o.fl_mul = 1'b1;
        state_d = ST_FL_FRAMES;
      end
      ST_FL_FRAMES: begin
        cmd_o.fl_frames = 1'b1;
        state_d = status_i.frames_zero ? flush_exit : ST_CH_UP;
      end
      ST_CH_UP: begin
        cmd_o.ch_up = 1'b1;
        state_d = ST_CH_DN;
      end
      ST_CH_DN: begin
        cmd_o.ch_dn = 1'b1;
        state_d = ST_CH_EMIT;
      end
      ST_CH_EMIT: begin
        cmd_o.emit_sel = SEL_CHUNK;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = status_i.last_chunk ? flush_exit : ST_CH_UP;
      end
      ST_SEG: begin
        cmd_o.seg_hit = status_i.seg_hit;
        if (status_i.seg_hit) begin
          state_d = ST_SEG_D0;
        end else if (pre_q) begin
          pre_d = 1'b0;
          state_d = ST_KIND;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SEG_D0: begin
        cmd_o.emit_sel = SEL_JUMP_OP;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = ST_SEG_LO;
      end
      ST_SEG_LO: begin
        cmd_o.emit_sel = SEL_SEG_LO;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = ST_SEG_HI;
      end
      ST_SEG_HI: begin
        cmd_o.emit_sel = SEL_SEG_HI;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) begin
          pre_d = 1'b0;
          state_d = pre_q ? ST_KIND : ST_DONE;
        end
      end
      ST_FIN_D0: begin
        cmd_o.emit_sel = SEL_JUMP_OP;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = ST_FIN_LO;
      end
      ST_FIN_LO: begin
        cmd_o.emit_sel = SEL_BASE_LO;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) state_d = ST_FIN_HI;
      end
      ST_FIN_HI: begin
        cmd_o.emit_sel = SEL_BASE_HI;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) begin
          cmd_o.stream_rst = 1'b1;
          phase_d = PH_CMD;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.close = status_i.done_ok;
        if (status_i.done_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_CMD;
      pre_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pre_q <= pre_d;
    end
  end

endmodule

// ----- hdl/tone_stream_transcoder.sv -----
`timescale 1ns / 1ps
// Tone stream transcoder top level: controller plus datapath.
// Depends on tst_pkg, tst_if, tst_ctrl and tst_dp.
//
// Usage:
//   in_if carries one source byte per transfer, stream_end set on the last one.
//   out_if carries converted bytes; run_last marks the last byte caused by a
//   source byte, jump_done the high address byte of a jump.
//   cfg_we_i/cfg_idx_i/cfg_data_i write base_address (0), segment_step (1),
//   segment_bytes (2) and timing_tolerance (3); write only while idle.
// Flow:
//   One source byte is in work at a time. A delay flush runs the start,
//   multiply and frames steps for the divide by 50, and each frame chunk
//   runs the chunk up, chunk down and chunk emit steps.
//   The last result is held in a staging register and released when the
//   step ends.
// Reset: asynchronous; stream state, configuration and control registers go to their reset values at once.
// Stall: a stalled receiver holds the output register and the controller
//   waits; no byte is lost, and the next source byte is taken while the final
//   result still sits in the output register.
module tone_stream_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  tst_in_if.sink      in_if,
  tst_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import tst_pkg::*;

  cmd_t    cmd;
  status_t status;

  tst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tst_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_byte_i    (in_if.in_byte),
    .stream_end_i (in_if.stream_end),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_byte_o   (out_if.out_byte),
    .run_last_o   (out_if.run_last),
    .jump_done_o  (out_if.jump_done)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("source byte taken while previous byte in work");

  a_staging_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !status.pend_valid)
    else $error("staged result left behind at end of step");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.pend_valid) |-> (!out_if.valid || out_if.ready))
    else $error("result pushed into a full output register");

endmodule
